[sv/prti_pkg.sv]
`default_nettype none

package prti_pkg;

    // Field and counter widths.
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 19;
    localparam int PR_W      = 13;
    localparam int CFG_IDX_W = 2;

    // Register limits and reset values.
    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_SIDES    = 64;
    localparam int MAX_RINGS    = 64;
    localparam int MIN_SIDES    = 3;
    localparam int RST_SEGMENTS = 1;
    localparam int RST_SIDES    = 3;
    localparam int RST_RINGS    = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RINGS    = 2'd2;

    typedef struct packed {
        logic accept;
        logic capture;
        logic calc;
        logic mod_start;
        logic emit;
    } prti_cmd_t;

    typedef struct packed {
        logic over;
        logic rem_done;
        logic out_free;
    } prti_status_t;

endpackage

`default_nettype wire

[sv/prti_rem.sv]
`default_nettype none

module prti_rem (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [prti_pkg::PR_W-1:0]  dividend,
    input  wire logic [prti_pkg::PR_W-1:0]  divisor,
    output logic                            done,
    output logic [prti_pkg::PR_W-1:0]       remainder
);
    import prti_pkg::*;

    localparam int STEP_W = $clog2(PR_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PR_W - 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PR_W:0]     rem_reg, rem_next;
    logic [PR_W-1:0]   dvd_reg, dvd_next;
    logic [PR_W-1:0]   div_reg, div_next;
    logic [PR_W:0]     trial;
    logic [PR_W:0]     wide_dvd;
    logic [PR_W:0]     wide_div;

    always_comb begin
        wide_dvd  = {1'b0, dividend};
        wide_div  = {1'b0, divisor};
        trial     = {rem_reg[PR_W-1:0], dvd_reg[PR_W-1]};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start) begin
            div_next = divisor;
            // Values below twice the divisor settle with at most a single subtract.
            if (wide_dvd < wide_div) begin
                rem_next = wide_dvd;
            end else if (wide_dvd < {divisor, 1'b0}) begin
                rem_next = wide_dvd - wide_div;
            end else begin
                rem_next  = '0;
                dvd_next  = dividend;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            // One restoring step per cycle, most significant bit first.
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
            end else begin
                rem_next = trial;
            end
            dvd_next = {dvd_reg[PR_W-2:0], 1'b0};
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done      = !busy_reg;
    assign remainder = rem_reg[PR_W-1:0];

endmodule

`default_nettype wire

[sv/prti_datapath.sv]
`default_nettype none

module prti_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire prti_pkg::prti_cmd_t             cmd,
    output prti_pkg::prti_status_t               status,
    input  wire logic                            s_restart,
    input  wire logic                            cfg_valid,
    input  wire logic [prti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [prti_pkg::CNT_W-1:0]      cfg_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [prti_pkg::IDX_W-1:0]           m_index_a,
    output logic [prti_pkg::IDX_W-1:0]           m_index_b,
    output logic [prti_pkg::IDX_W-1:0]           m_index_c,
    output logic                                 m_final_triangle,
    output logic                                 m_finished
);
    import prti_pkg::*;

    logic [CNT_W-1:0] seg_reg, seg_next;
    logic [CNT_W-1:0] side_reg, side_next;
    logic [CNT_W-1:0] ring_reg, ring_next;
    logic [CNT_W-1:0] clamped;

    logic [CNT_W-1:0] seg_pos_reg, seg_pos_next;
    logic [CNT_W-1:0] side_pos_reg, side_pos_next;
    logic [CNT_W-1:0] ring_pos_reg, ring_pos_next;
    logic             half_reg, half_next;

    logic             over_reg;
    logic [PR_W-1:0]  per_ring_reg;
    logic [PR_W-1:0]  side_prod_reg;
    logic [IDX_W-1:0] base_reg;
    logic [PR_W-1:0]  n1_reg;

    logic [2*CNT_W-1:0]      pr_full;
    logic [2*CNT_W-1:0]      sp_full;
    logic [CNT_W+PR_W-1:0]   base_full;

    logic             rem_done;
    logic [PR_W-1:0]  n2;

    logic             over_now;
    logic             innermost;
    logic [CNT_W-1:0] seg_inc, side_inc, ring_inc;
    logic [CNT_W-1:0] adv_seg, adv_side, adv_ring;
    logic             adv_half;
    logic             final_now;
    logic [IDX_W-1:0] n1x, n2x, prx;
    logic [IDX_W-1:0] tri_a, tri_b, tri_c;

    logic             m_valid_reg;
    logic [IDX_W-1:0] a_reg, b_reg, c_reg;
    logic             final_reg, finished_reg;

    // Configuration registers; values above the limit saturate.
    always_comb begin
        seg_next  = seg_reg;
        side_next = side_reg;
        ring_next = ring_reg;
        clamped   = cfg_data;
        case (cfg_index)
            REG_SEGMENTS: begin
                if (cfg_data > CNT_W'(MAX_SEGMENTS)) clamped = CNT_W'(MAX_SEGMENTS);
                if (cfg_valid) seg_next = clamped;
            end
            REG_SIDES: begin
                if (cfg_data > CNT_W'(MAX_SIDES)) clamped = CNT_W'(MAX_SIDES);
                if (cfg_valid) side_next = clamped;
            end
            REG_RINGS: begin
                if (cfg_data > CNT_W'(MAX_RINGS)) clamped = CNT_W'(MAX_RINGS);
                if (cfg_valid) ring_next = clamped;
            end
            default: begin
            end
        endcase
    end

    assign over_now = (seg_reg == '0) || (side_reg < CNT_W'(MIN_SIDES))
                   || (ring_pos_reg >= ring_reg);

    assign pr_full   = (2*CNT_W)'(seg_reg) * (2*CNT_W)'(side_reg);
    assign sp_full   = (2*CNT_W)'(side_pos_reg) * (2*CNT_W)'(seg_reg);
    assign base_full = (CNT_W+PR_W)'(ring_pos_reg) * (CNT_W+PR_W)'(per_ring_reg);

    prti_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (n1_reg + PR_W'(1)),
        .divisor   (per_ring_reg),
        .done      (rem_done),
        .remainder (n2)
    );

    // Walk advance and triangle selection for the emit cycle.
    always_comb begin
        innermost = ((ring_pos_reg + CNT_W'(1)) == ring_reg);
        seg_inc   = seg_pos_reg + CNT_W'(1);
        side_inc  = side_pos_reg + CNT_W'(1);
        ring_inc  = ring_pos_reg + CNT_W'(1);
        adv_seg   = seg_pos_reg;
        adv_side  = side_pos_reg;
        adv_ring  = ring_pos_reg;
        adv_half  = innermost ? half_reg : !half_reg;
        if (innermost || half_reg) begin
            adv_seg = seg_inc;
            if (seg_inc >= seg_reg) begin
                adv_seg  = '0;
                adv_side = side_inc;
                if (side_inc >= side_reg) begin
                    adv_side = '0;
                    adv_half = 1'b0;
                    adv_ring = ring_inc;
                end
            end
        end
        final_now = (seg_reg == '0) || (side_reg < CNT_W'(MIN_SIDES))
                 || (adv_ring >= ring_reg);

        n1x = IDX_W'(n1_reg) + base_reg;
        n2x = IDX_W'(n2) + base_reg;
        prx = IDX_W'(per_ring_reg);
        if (innermost) begin
            tri_a = '0;
            tri_b = n1x;
            tri_c = n2x;
        end else if (!half_reg) begin
            tri_a = n1x;
            tri_b = n2x;
            tri_c = n1x + prx;
        end else begin
            tri_a = n2x;
            tri_b = n2x + prx;
            tri_c = n1x + prx;
        end
    end

    always_comb begin
        seg_pos_next  = seg_pos_reg;
        side_pos_next = side_pos_reg;
        ring_pos_next = ring_pos_reg;
        half_next     = half_reg;
        if (cmd.accept && s_restart) begin
            seg_pos_next  = '0;
            side_pos_next = '0;
            ring_pos_next = '0;
            half_next     = 1'b0;
        end else if (cmd.emit && !over_reg) begin
            seg_pos_next  = adv_seg;
            side_pos_next = adv_side;
            ring_pos_next = adv_ring;
            half_next     = adv_half;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg      <= CNT_W'(RST_SEGMENTS);
            side_reg     <= CNT_W'(RST_SIDES);
            ring_reg     <= CNT_W'(RST_RINGS);
            seg_pos_reg  <= '0;
            side_pos_reg <= '0;
            ring_pos_reg <= '0;
            half_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            seg_reg      <= seg_next;
            side_reg     <= side_next;
            ring_reg     <= ring_next;
            seg_pos_reg  <= seg_pos_next;
            side_pos_reg <= side_pos_next;
            ring_pos_reg <= ring_pos_next;
            half_reg     <= half_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            over_reg      <= over_now;
            per_ring_reg  <= pr_full[PR_W-1:0];
            side_prod_reg <= sp_full[PR_W-1:0];
        end
        if (cmd.calc) begin
            base_reg <= base_full[IDX_W-1:0] + IDX_W'(1);
            n1_reg   <= side_prod_reg + PR_W'(seg_pos_reg);
        end
        if (cmd.emit) begin
            if (over_reg) begin
                a_reg        <= '0;
                b_reg        <= '0;
                c_reg        <= '0;
                final_reg    <= 1'b0;
                finished_reg <= 1'b1;
            end else begin
                a_reg        <= tri_a;
                b_reg        <= tri_b;
                c_reg        <= tri_c;
                final_reg    <= final_now;
                finished_reg <= 1'b0;
            end
        end
    end

    assign status.over     = over_now;
    assign status.rem_done = rem_done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_index_a        = a_reg;
    assign m_index_b        = b_reg;
    assign m_index_c        = c_reg;
    assign m_final_triangle = final_reg;
    assign m_finished       = finished_reg;

endmodule

`default_nettype wire

[sv/prti_ctrl.sv]
`default_nettype none

module prti_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire prti_pkg::prti_status_t status,
    output prti_pkg::prti_cmd_t         cmd
);
    import prti_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.capture = 1'b1;
                state_next  = status.over ? ST_EMIT : ST_MUL;
            end
            ST_MUL: begin
                cmd.calc   = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.mod_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.rem_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/polygon_ring_triangle_indexer_core.sv]
// A triangle request passes the check, multiply, remainder start, remainder wait and
// emit states before its result is registered; a finished or degenerate one skips to emit.
// A new request is taken only after the last is emitted; emit waits for a free output.
// After a configuration change in mid-walk the ring remainder may need the full division.
// Reset (aresetn low, synchronous) restores the default configuration and rewinds the walk.
`default_nettype none

module polygon_ring_triangle_indexer_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Request channel: one request asks for the next triangle of the walk.
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_restart,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [prti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [prti_pkg::CNT_W-1:0]      cfg_data,
    // Result channel.
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [prti_pkg::IDX_W-1:0]           m_index_a,
    output logic [prti_pkg::IDX_W-1:0]           m_index_b,
    output logic [prti_pkg::IDX_W-1:0]           m_index_c,
    output logic                                 m_final_triangle,
    output logic                                 m_finished
);
    import prti_pkg::*;

    // The controller sequences a request through capture of the products, the
    // base and position sums, the wrap of the next ring position and the load
    // of the output register; a finished or degenerate one skips to the load.
    // Datapath: configuration, walk counters, arithmetic and output register.
    prti_cmd_t    cmd;
    prti_status_t status;

    // Configuration writes always taken; user must issue them only while idle, unchecked.
    assign cfg_ready = 1'b1;

    prti_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The output register lets a new request be taken while a result waits.
    prti_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_restart        (s_restart),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_index_a        (m_index_a),
        .m_index_b        (m_index_b),
        .m_index_c        (m_index_c),
        .m_final_triangle (m_final_triangle),
        .m_finished       (m_finished)
    );

endmodule

`default_nettype wire

[sv/prti_checker.sv]
`default_nettype none

module prti_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [prti_pkg::IDX_W-1:0]      m_index_a,
    input wire logic [prti_pkg::IDX_W-1:0]      m_index_b,
    input wire logic [prti_pkg::IDX_W-1:0]      m_index_c,
    input wire logic                            m_final_triangle,
    input wire logic                            m_finished
);
    import prti_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_index_a) && $stable(m_index_b)
            && $stable(m_index_c) && $stable(m_finished) && $stable(m_final_triangle))
        else $error("stalled result changed");

    // A finished result carries no triangle.
    a_finished_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_index_a == '0 && m_index_b == '0
            && m_index_c == '0 && !m_final_triangle)
        else $error("finished result carries triangle data");

    // One request at a time: the block is busy right after taking one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind polygon_ring_triangle_indexer_core prti_checker u_prti_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_index_a        (m_index_a),
    .m_index_b        (m_index_b),
    .m_index_c        (m_index_c),
    .m_final_triangle (m_final_triangle),
    .m_finished       (m_finished)
);

`default_nettype wire
